[sv/rhpm_pkg.sv]
// Shared types and constants for the rolling hash pattern matcher.
// No dependencies; imported by the core, the reduction unit and the checker.
package rhpm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

   localparam int SYM_W  = 8;
   localparam int POS_W  = 24;
   localparam int HASH_W = 17;

   localparam logic [SYM_W-1:0]  HASH_BASE = 8'd101;
   localparam logic [HASH_W-1:0] HASH_MOD  = 17'd100019;

   // Reciprocal reduction: q = (x * HASH_RECIP) >> RECIP_SHIFT is floor(x / HASH_MOD)
   // or one less, for every x below 2^PROD_W.
   localparam int PROD_W      = HASH_W + SYM_W;
   localparam int RECIP_SHIFT = 42;
   localparam int RECIP_W     = RECIP_SHIFT - HASH_W + 1;
   localparam logic [RECIP_W-1:0] HASH_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(HASH_MOD));
   localparam int Q_W = PROD_W + RECIP_W - RECIP_SHIFT;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   // Request to the modular multiply-add unit: (a * b + c) mod HASH_MOD.
   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] a;
      logic [SYM_W-1:0]  b;
      logic [SYM_W-1:0]  c;
   } mm_req_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] value;
   } mm_rsp_type;

endpackage

[sv/rhpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rhpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rhpm_mulmod.sv]
// Four-stage pipelined (a * b + c) mod HASH_MOD with reciprocal reduction.
// Depends on rhpm_pkg.
module rhpm_mulmod
   import rhpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mm_req_type mm_req,
   output mm_rsp_type mm_rsp
);

   logic [PROD_W-1:0]          x1_ff;
   logic [PROD_W-1:0]          x2_ff;
   logic [Q_W-1:0]             q_ff;
   logic [HASH_W:0]            r_ff;
   logic [HASH_W-1:0]          value_ff;
   logic [2:0]                 vld_ff;
   logic                       done_ff;

   logic [PROD_W+RECIP_W-1:0]  recip_prod;
   logic [PROD_W:0]            qm_prod;
   logic [PROD_W:0]            diff;

   assign recip_prod = PROD_W'(x1_ff) * (PROD_W+RECIP_W)'(HASH_RECIP);
   assign qm_prod    = (PROD_W+1)'(q_ff) * (PROD_W+1)'(HASH_MOD);
   assign diff       = (PROD_W+1)'(x2_ff) - qm_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[1:0], mm_req.start};
         done_ff <= vld_ff[2];
      end
      // stage 1: multiply-add
      x1_ff <= PROD_W'(mm_req.a) * PROD_W'(mm_req.b) + PROD_W'(mm_req.c);
      // stage 2: quotient estimate
      x2_ff <= x1_ff;
      q_ff  <= recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
      // stage 3: remainder, below 2 * HASH_MOD
      r_ff  <= diff[HASH_W:0];
      // stage 4: single correction
      if (r_ff >= (HASH_W+1)'(HASH_MOD)) begin
         value_ff <= HASH_W'(r_ff - (HASH_W+1)'(HASH_MOD));
      end else begin
         value_ff <= HASH_W'(r_ff);
      end
   end

   assign mm_rsp.done  = done_ff;
   assign mm_rsp.value = value_ff;

endmodule

[sv/rolling_hash_pattern_matcher_core.sv]
// Streaming Rabin-Karp pattern matcher, top level.
// Depends on rhpm_pkg, rhpm_ram and rhpm_mulmod.
//
// Pattern symbols (append op) are stored in a 32-entry pattern RAM while the
// pattern hash and the lead weight 101^(m-1) are built modulo 100019. Text
// symbols then stream in: a 32-entry ring RAM holds the last m symbols and a
// rolling hash is updated per symbol. On a hash hit over a full window, the
// window is read back from the ring and compared with the pattern RAM one
// symbol at a time; a verified match returns its start position
// (modulo 2^24, counted from the last restart) on the rsp channel. Appending a
// pattern symbol also restarts the text. One item is in flight at a time.
// Clear and restart need no hash work. Appends and text symbols go through the
// four-stage modular reduction unit, once per symbol or twice in series when
// the pattern is non-empty or the oldest symbol is dropped; a hash hit adds a
// read and a compare step per compared symbol, as the RAM ports give one read
// per cycle. A result waiting in the output register does not block new
// transfers on req; the block only holds in its report step when a second
// match finds the output register still full.
module rolling_hash_pattern_matcher_core
   import rhpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [SYM_W-1:0] req_symbol,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [POS_W-1:0] rsp_match_start
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAT_HASH,
      ST_PAT_WEIGHT,
      ST_OLD_TERM,
      ST_DROP_OLD,
      ST_ROLL,
      ST_NEW_HASH,
      ST_VFY_READ,
      ST_VFY_CMP,
      ST_REPORT
   } state_type;

   state_type         state_ff;

   logic [CNT_W-1:0]  pat_count_ff;
   logic [HASH_W-1:0] pat_hash_ff;
   logic [HASH_W-1:0] lead_weight_ff;
   logic [HASH_W-1:0] win_hash_ff;
   logic [POS_W-1:0]  text_pos_ff;
   logic [CNT_W-1:0]  win_fill_ff;
   logic [PTR_W-1:0]  ring_head_ff;
   logic [PTR_W-1:0]  vfy_idx_ff;
   logic [PTR_W-1:0]  win_start_ff;
   logic [SYM_W-1:0]  sym_ff;
   logic [HASH_W-1:0] drop_ff;
   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_start_ff;

   mm_req_type        mm_req;
   mm_rsp_type        mm_rsp;

   logic              req_fire;
   op_type            req_code;
   logic              pat_full;
   logic              win_full;
   logic [PTR_W-1:0]  head_inc;
   logic [PTR_W-1:0]  oldest_addr;
   logic [PTR_W-1:0]  start_next;
   logic [PTR_W-1:0]  vfy_addr;
   logic [CNT_W-1:0]  fill_next;
   logic              vfy_last;
   logic [HASH_W:0]   drop_sum;
   logic [HASH_W-1:0] drop_value;
   logic              hash_hit;

   logic [PTR_W-1:0]  ring_rd_addr;
   logic [SYM_W-1:0]  ring_rd_data;
   logic              ring_wr_en;
   logic              pat_wr_en;
   logic [SYM_W-1:0]  pat_rd_data;

   // reduce a sum below 2 * MAX_PATTERN to a ring slot
   function automatic logic [PTR_W-1:0] ring_wrap(input logic [CNT_W:0] sum);
      logic [CNT_W:0] wrapped;
      if (sum >= (CNT_W+1)'(MAX_PATTERN)) begin
         wrapped = sum - (CNT_W+1)'(MAX_PATTERN);
      end else begin
         wrapped = sum;
      end
      return wrapped[PTR_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_code  = op_type'(req_op);

   assign pat_full = (pat_count_ff >= CNT_W'(MAX_PATTERN));
   assign win_full = (pat_count_ff != '0) && (win_fill_ff >= pat_count_ff);

   assign head_inc = (ring_head_ff == PTR_W'(MAX_PATTERN - 1)) ? '0
                                                             : ring_head_ff + 1'b1;

   // slot of the oldest window symbol, before the new one is written
   assign oldest_addr = ring_wrap((CNT_W+1)'(ring_head_ff) + (CNT_W+1)'(MAX_PATTERN)
                                  - (CNT_W+1)'(pat_count_ff));
   // first window slot after the new symbol is written
   assign start_next  = ring_wrap((CNT_W+1)'(head_inc) + (CNT_W+1)'(MAX_PATTERN)
                                  - (CNT_W+1)'(pat_count_ff));
   assign vfy_addr    = ring_wrap((CNT_W+1)'(win_start_ff) + (CNT_W+1)'(vfy_idx_ff));

   assign fill_next = (win_fill_ff < pat_count_ff) ? win_fill_ff + 1'b1 : win_fill_ff;
   assign vfy_last  = ((CNT_W)'(vfy_idx_ff) == pat_count_ff - 1'b1);

   // window hash minus the oldest term, modulo HASH_MOD
   assign drop_sum   = (HASH_W+1)'(win_hash_ff) + (HASH_W+1)'(HASH_MOD)
                       - (HASH_W+1)'(mm_rsp.value);
   assign drop_value = (drop_sum >= (HASH_W+1)'(HASH_MOD))
                       ? HASH_W'(drop_sum - (HASH_W+1)'(HASH_MOD))
                       : HASH_W'(drop_sum);

   assign hash_hit = (pat_count_ff != '0) && (fill_next >= pat_count_ff)
                     && (mm_rsp.value == pat_hash_ff);

   // reduction unit requests
   always_comb begin
      mm_req = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_code == OP_APPEND && !pat_full) begin
               mm_req.start = 1'b1;
               mm_req.a     = pat_hash_ff;
               mm_req.b     = HASH_BASE;
               mm_req.c     = req_symbol;
            end else if (req_fire && req_code == OP_TEXT && !win_full) begin
               mm_req.start = 1'b1;
               mm_req.a     = win_hash_ff;
               mm_req.b     = HASH_BASE;
               mm_req.c     = req_symbol;
            end
         end
         ST_PAT_HASH: begin
            if (mm_rsp.done && pat_count_ff != '0) begin
               mm_req.start = 1'b1;
               mm_req.a     = lead_weight_ff;
               mm_req.b     = HASH_BASE;
            end
         end
         ST_OLD_TERM: begin
            mm_req.start = 1'b1;
            mm_req.a     = lead_weight_ff;
            mm_req.b     = ring_rd_data;
         end
         ST_ROLL: begin
            mm_req.start = 1'b1;
            mm_req.a     = drop_ff;
            mm_req.b     = HASH_BASE;
            mm_req.c     = sym_ff;
         end
         default: begin
            mm_req = '0;
         end
      endcase
   end

   rhpm_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   // ring reads the oldest slot except while verifying
   assign ring_rd_addr = (state_ff == ST_VFY_READ) ? vfy_addr : oldest_addr;
   assign ring_wr_en   = (state_ff == ST_NEW_HASH) && mm_rsp.done;
   assign pat_wr_en    = req_fire && (req_code == OP_APPEND) && !pat_full;

   rhpm_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_PATTERN)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_head_ff),
      .wr_data (sym_ff),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   rhpm_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (pat_count_ff[PTR_W-1:0]),
      .wr_data (req_symbol),
      .rd_addr (vfy_idx_ff),
      .rd_data (pat_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pat_count_ff   <= '0;
         pat_hash_ff    <= '0;
         lead_weight_ff <= HASH_W'(1);
         win_hash_ff    <= '0;
         text_pos_ff    <= '0;
         win_fill_ff    <= '0;
         ring_head_ff   <= '0;
         vfy_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // a new result takes the output register, a taken one frees it
         if (state_ff == ST_REPORT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_code)
                     OP_CLEAR: begin
                        pat_count_ff   <= '0;
                        pat_hash_ff    <= '0;
                        lead_weight_ff <= HASH_W'(1);
                        win_hash_ff    <= '0;
                        text_pos_ff    <= '0;
                        win_fill_ff    <= '0;
                        ring_head_ff   <= '0;
                     end
                     OP_APPEND: begin
                        win_hash_ff  <= '0;
                        text_pos_ff  <= '0;
                        win_fill_ff  <= '0;
                        ring_head_ff <= '0;
                        if (!pat_full) begin
                           state_ff <= ST_PAT_HASH;
                        end
                     end
                     OP_TEXT: begin
                        sym_ff   <= req_symbol;
                        state_ff <= win_full ? ST_OLD_TERM : ST_NEW_HASH;
                     end
                     OP_RESTART: begin
                        win_hash_ff  <= '0;
                        text_pos_ff  <= '0;
                        win_fill_ff  <= '0;
                        ring_head_ff <= '0;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end

            ST_PAT_HASH: begin
               if (mm_rsp.done) begin
                  pat_hash_ff <= mm_rsp.value;
                  if (pat_count_ff == '0) begin
                     pat_count_ff <= pat_count_ff + 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_PAT_WEIGHT;
                  end
               end
            end

            ST_PAT_WEIGHT: begin
               if (mm_rsp.done) begin
                  lead_weight_ff <= mm_rsp.value;
                  pat_count_ff   <= pat_count_ff + 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end

            ST_OLD_TERM: begin
               state_ff <= ST_DROP_OLD;
            end

            ST_DROP_OLD: begin
               if (mm_rsp.done) begin
                  drop_ff  <= drop_value;
                  state_ff <= ST_ROLL;
               end
            end

            ST_ROLL: begin
               state_ff <= ST_NEW_HASH;
            end

            ST_NEW_HASH: begin
               if (mm_rsp.done) begin
                  win_hash_ff  <= mm_rsp.value;
                  ring_head_ff <= head_inc;
                  text_pos_ff  <= text_pos_ff + 1'b1;
                  win_fill_ff  <= fill_next;
                  win_start_ff <= start_next;
                  vfy_idx_ff   <= '0;
                  state_ff     <= hash_hit ? ST_VFY_READ : ST_IDLE;
               end
            end

            ST_VFY_READ: begin
               state_ff <= ST_VFY_CMP;
            end

            ST_VFY_CMP: begin
               if (ring_rd_data != pat_rd_data) begin
                  state_ff <= ST_IDLE;
               end else if (vfy_last) begin
                  state_ff <= ST_REPORT;
               end else begin
                  vfy_idx_ff <= vfy_idx_ff + 1'b1;
                  state_ff   <= ST_VFY_READ;
               end
            end

            ST_REPORT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_start_ff <= text_pos_ff - POS_W'(pat_count_ff);
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_start = rsp_start_ff;

endmodule

[sv/rhpm_checker.sv]
// Port-level assertions for the rolling hash pattern matcher core.
// Depends on rhpm_pkg; bound to rolling_hash_pattern_matcher_core below.
module rhpm_checker
   import rhpm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [1:0]       req_op,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_match_start
);

   // reset leaves the block ready with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_start))
      else $error("result changed while stalled");

   // clear and restart finish in the transfer cycle
   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_CLEAR || req_op == OP_RESTART)
      |=> req_ready)
      else $error("clear or restart did not complete at once");

   // a text symbol always needs hash work before the next transfer
   a_text_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_TEXT |=> !req_ready)
      else $error("text symbol finished without a hash update");

endmodule

bind rolling_hash_pattern_matcher_core rhpm_checker u_rhpm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_op          (req_op),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_start (rsp_match_start)
);
